@@ rtl/gradient_predictor_decoder_core_defines.svh @@
// Assertion macros shared by the gradient predictor decoder RTL.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef GRADIENT_PREDICTOR_DECODER_CORE_DEFINES_SVH
`define GRADIENT_PREDICTOR_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define GPD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define GPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gpd_pkg.sv @@
// Package of the gradient predictor decoder: payload and config types, codes, defaults.
// Depends on nothing; the top level, gpd_predict and gpd_scale_div refer to it by scoped names.
package gpd_pkg;

    localparam int MAX_ROW_WIDTH_DEF = 2048;
    localparam int CHANNEL_BITS_DEF  = 16;
    localparam int CFG_DATA_W        = 16;
    localparam int CFG_IDX_W         = 3;
    localparam int ROW_WIDTH_W       = 12;
    localparam int SHIFT_W           = 5;
    localparam int OUT_W             = 8;
    localparam int NUM_CH            = 3;

    typedef struct packed {
        logic [31:0] residual_word;
        logic        rect_start;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] red_out;
        logic [OUT_W-1:0] green_out;
        logic [OUT_W-1:0] blue_out;
        logic             row_end;
    } t_out_item;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_MAX     = 3'd0,
        CFG_GREEN_MAX   = 3'd1,
        CFG_BLUE_MAX    = 3'd2,
        CFG_RED_SHIFT   = 3'd3,
        CFG_GREEN_SHIFT = 3'd4,
        CFG_BLUE_SHIFT  = 3'd5,
        CFG_ROW_WIDTH   = 3'd6
    } t_cfg_idx;

    // Lane 0 is red, lane 1 green, lane 2 blue.
    typedef struct packed {
        logic [NUM_CH-1:0][CFG_DATA_W-1:0] max;
        logic [NUM_CH-1:0][SHIFT_W-1:0]    shift;
    } t_chan_cfg;

    typedef struct packed {
        logic first_row;
        logic row_first;
    } t_nbr_flags;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CALC = 2'd1,
        S_DIV  = 2'd2
    } t_state;

endpackage

@@ rtl/gradient_predictor_decoder_core.sv @@
// Top level of the gradient predictor decoder: config registers, sequencer, output register.
// Depends on gpd_pkg, gpd_row_store, gpd_predict, gpd_scale_div and the defines header.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_in_data   (gpd_pkg::t_in_item)
//   output    out        o_out_valid / i_out_ready  o_out_data  (gpd_pkg::t_out_item)
//   config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// Each pixel passes through the row-store read, prediction and write-back, the restoring
// divider that scales each channel to eight bits, and the output register load before the
// next pixel can be transferred in. Reset is synchronous; the row store is not cleared.
// A new pixel is accepted while a result still waits in the output register; the sequencer
// holds at the end of the division only if the output register is still full.
// The user must see that the row store is only read where written; the block does not check.
`include "gradient_predictor_decoder_core_defines.svh"

module gradient_predictor_decoder_core #(
    parameter int MAX_ROW_WIDTH = gpd_pkg::MAX_ROW_WIDTH_DEF,
    parameter int CHANNEL_BITS  = gpd_pkg::CHANNEL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  gpd_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output gpd_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [gpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CB    = CHANNEL_BITS;
    localparam int NC    = gpd_pkg::NUM_CH;
    localparam int COL_W = $clog2(MAX_ROW_WIDTH);
    localparam int RW    = gpd_pkg::ROW_WIDTH_W;
    localparam int WW    = ((COL_W + 1) > RW) ? (COL_W + 1) : RW;

    gpd_pkg::t_state    r_state;
    gpd_pkg::t_state    n_state;
    gpd_pkg::t_chan_cfg r_cfg;
    logic [RW-1:0]      r_row_width;

    logic [COL_W-1:0]   r_col;
    logic               r_first;
    logic [NC-1:0][CB-1:0] r_left;
    logic [NC-1:0][CB-1:0] r_ul;

    logic [31:0]         r_cur_word;
    logic [COL_W-1:0]    r_cur_col;
    gpd_pkg::t_nbr_flags r_cur_flags;
    logic                r_cur_row_end;

    logic               r_out_valid;
    gpd_pkg::t_out_item r_out_data;

    logic               in_xfer;
    logic               out_xfer;
    logic               in_ready;
    logic               div_start;
    logic               mem_we;
    logic               load_out;
    logic               div_done;

    logic [COL_W-1:0]   col_eff;
    logic               first_eff;
    logic [COL_W:0]     col_inc;
    logic [WW-1:0]      w_eff;
    logic               row_end;

    logic [NC*CB-1:0]      rd_data;
    logic [NC-1:0][CB-1:0] up_rd;
    logic [NC-1:0][CB-1:0] pix;
    logic [NC-1:0][CB-1:0] up_used;
    logic [NC-1:0][CB-1:0] max_lane;
    logic [NC-1:0][gpd_pkg::OUT_W-1:0] q;

    assign in_xfer  = i_in_valid && in_ready;
    assign out_xfer = r_out_valid && i_out_ready;

    always_comb begin
        col_eff   = i_in_data.rect_start ? '0 : r_col;
        first_eff = i_in_data.rect_start || r_first;
        col_inc   = {1'b0, col_eff} + 1'b1;
        if (r_row_width == '0) begin
            w_eff = WW'(1);
        end else if (WW'(r_row_width) > WW'(MAX_ROW_WIDTH)) begin
            w_eff = WW'(MAX_ROW_WIDTH);
        end else begin
            w_eff = WW'(r_row_width);
        end
        row_end = WW'(col_inc) >= w_eff;
    end

    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            gpd_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = gpd_pkg::S_CALC;
                end
            end
            gpd_pkg::S_CALC: begin
                div_start = 1'b1;
                mem_we    = 1'b1;
                n_state   = gpd_pkg::S_DIV;
            end
            gpd_pkg::S_DIV: begin
                if (div_done && (!r_out_valid || i_out_ready)) begin
                    load_out = 1'b1;
                    n_state  = gpd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gpd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gpd_pkg::S_IDLE;
            r_cfg.max   <= {NC{gpd_pkg::CFG_DATA_W'(255)}};
            r_cfg.shift <= {gpd_pkg::SHIFT_W'(0), gpd_pkg::SHIFT_W'(8), gpd_pkg::SHIFT_W'(16)};
            r_row_width <= RW'(1);
            r_col       <= '0;
            r_first     <= 1'b1;
            r_left      <= '0;
            r_ul        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (gpd_pkg::t_cfg_idx'(i_cfg_index))
                    gpd_pkg::CFG_RED_MAX:     r_cfg.max[0]   <= i_cfg_data;
                    gpd_pkg::CFG_GREEN_MAX:   r_cfg.max[1]   <= i_cfg_data;
                    gpd_pkg::CFG_BLUE_MAX:    r_cfg.max[2]   <= i_cfg_data;
                    gpd_pkg::CFG_RED_SHIFT:   r_cfg.shift[0] <= i_cfg_data[gpd_pkg::SHIFT_W-1:0];
                    gpd_pkg::CFG_GREEN_SHIFT: r_cfg.shift[1] <= i_cfg_data[gpd_pkg::SHIFT_W-1:0];
                    gpd_pkg::CFG_BLUE_SHIFT:  r_cfg.shift[2] <= i_cfg_data[gpd_pkg::SHIFT_W-1:0];
                    gpd_pkg::CFG_ROW_WIDTH:   r_row_width    <= i_cfg_data[RW-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_xfer) begin
                r_col   <= row_end ? '0 : col_inc[COL_W-1:0];
                r_first <= row_end ? 1'b0 : first_eff;
            end
            if (mem_we) begin
                r_left <= pix;
                r_ul   <= up_used;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cur_word            <= i_in_data.residual_word;
            r_cur_col             <= col_eff;
            r_cur_flags.first_row <= first_eff;
            r_cur_flags.row_first <= (col_eff == '0);
            r_cur_row_end         <= row_end;
        end
        if (load_out) begin
            r_out_data.red_out   <= q[0];
            r_out_data.green_out <= q[1];
            r_out_data.blue_out  <= q[2];
            r_out_data.row_end   <= r_cur_row_end;
        end
    end

    gpd_row_store #(
        .DEPTH  (MAX_ROW_WIDTH),
        .DATA_W (NC * CB),
        .ADDR_W (COL_W)
    ) u_row_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_xfer),
        .i_rd_addr (col_eff),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_we),
        .i_wr_addr (r_cur_col),
        .i_wr_data (pix)
    );

    assign up_rd = rd_data;

    gpd_predict #(
        .CHANNEL_BITS (CB)
    ) u_predict (
        .i_word  (r_cur_word),
        .i_cfg   (r_cfg),
        .i_flags (r_cur_flags),
        .i_up    (up_rd),
        .i_left  (r_left),
        .i_ul    (r_ul),
        .o_pix   (pix),
        .o_up    (up_used)
    );

    always_comb begin
        for (int c = 0; c < NC; c++) begin
            max_lane[c] = r_cfg.max[c][CB-1:0];
        end
    end

    gpd_scale_div #(
        .CHANNEL_BITS (CB)
    ) u_scale_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_pix   (pix),
        .i_max   (max_lane),
        .o_done  (div_done),
        .o_q     (q)
    );

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `GPD_ASSERT_NEXT(a_accept_to_calc, i_clk, i_rst_n, in_xfer, r_state == gpd_pkg::S_CALC, "accepted pixel did not move to the compute step")
    `GPD_ASSERT_SAME(a_load_needs_room, i_clk, i_rst_n, load_out, div_done && (!r_out_valid || i_out_ready), "output register loaded while full or before the division finished")
    `GPD_ASSERT_SAME(a_col_in_range, i_clk, i_rst_n, 1'b1, {1'b0, r_col} < (COL_W + 1)'(MAX_ROW_WIDTH), "column counter beyond the row store")
    `GPD_ASSERT_NEXT(a_calc_starts_div, i_clk, i_rst_n, r_state == gpd_pkg::S_CALC, (r_state == gpd_pkg::S_DIV) && !div_done, "division not started after the compute step")

endmodule

@@ rtl/gpd_row_store.sv @@
// Previous-row store: single-port-write, registered-read synchronous memory.
// Uses no package items; instantiated by the top level.
module gpd_row_store #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 48,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/gpd_predict.sv @@
// Gradient prediction and channel reconstruction for three independent lanes.
// Depends on gpd_pkg for the channel config and neighbour flag types.
module gpd_predict #(
    parameter int CHANNEL_BITS = gpd_pkg::CHANNEL_BITS_DEF
) (
    input  logic [31:0]                                i_word,
    input  gpd_pkg::t_chan_cfg                         i_cfg,
    input  gpd_pkg::t_nbr_flags                        i_flags,
    input  logic [gpd_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] i_up,
    input  logic [gpd_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] i_left,
    input  logic [gpd_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] i_ul,
    output logic [gpd_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] o_pix,
    output logic [gpd_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] o_up
);

    localparam int CB = CHANNEL_BITS;
    localparam int EW = CB + 2;

    logic [gpd_pkg::NUM_CH-1:0][CB-1:0] up_v;
    logic [gpd_pkg::NUM_CH-1:0][CB-1:0] left_v;
    logic [gpd_pkg::NUM_CH-1:0][CB-1:0] ul_v;
    logic [gpd_pkg::NUM_CH-1:0][CB-1:0] max_v;
    logic [gpd_pkg::NUM_CH-1:0][31:0]   res_v;
    logic signed [gpd_pkg::NUM_CH-1:0][EW-1:0] est_v;
    logic [gpd_pkg::NUM_CH-1:0][CB-1:0] clamp_v;

    always_comb begin
        for (int c = 0; c < gpd_pkg::NUM_CH; c++) begin
            up_v[c]   = i_flags.first_row ? '0 : i_up[c];
            left_v[c] = i_flags.row_first ? '0 : i_left[c];
            ul_v[c]   = i_flags.row_first ? '0 : i_ul[c];
            max_v[c]  = i_cfg.max[c][CB-1:0];
            res_v[c]  = i_word >> i_cfg.shift[c];
            est_v[c]  = $signed({2'b00, left_v[c]}) + $signed({2'b00, up_v[c]})
                      - $signed({2'b00, ul_v[c]});
            if ($signed(est_v[c]) > $signed({2'b00, max_v[c]})) begin
                clamp_v[c] = max_v[c];
            end else if ($signed(est_v[c]) < $signed({EW{1'b0}})) begin
                clamp_v[c] = '0;
            end else begin
                clamp_v[c] = est_v[c][CB-1:0];
            end
            o_pix[c] = (res_v[c][CB-1:0] + clamp_v[c]) & max_v[c];
            o_up[c]  = up_v[c];
        end
    end

endmodule

@@ rtl/gpd_scale_div.sv @@
// Iterative restoring divider, three lanes, one quotient bit per cycle: pix*255/max.
// Depends on gpd_pkg for the lane count and the output width.
module gpd_scale_div #(
    parameter int CHANNEL_BITS = gpd_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [gpd_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] i_pix,
    input  logic [gpd_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0] i_max,
    output logic                                         o_done,
    output logic [gpd_pkg::NUM_CH-1:0][gpd_pkg::OUT_W-1:0] o_q
);

    localparam int CB    = CHANNEL_BITS;
    localparam int QW    = gpd_pkg::OUT_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic                                 r_busy;
    logic                                 r_done;
    logic [CNT_W-1:0]                     r_cnt;
    logic [gpd_pkg::NUM_CH-1:0][CB-1:0]   r_rem;
    logic [gpd_pkg::NUM_CH-1:0][QW-1:0]   r_low;
    logic [gpd_pkg::NUM_CH-1:0][QW-1:0]   r_q;
    logic [gpd_pkg::NUM_CH-1:0][CB-1:0]   r_max;

    logic [gpd_pkg::NUM_CH-1:0][CB+QW-1:0] prod;
    logic [gpd_pkg::NUM_CH-1:0][CB:0]      trial;
    logic [gpd_pkg::NUM_CH-1:0]            take;

    always_comb begin
        for (int c = 0; c < gpd_pkg::NUM_CH; c++) begin
            prod[c]  = {i_pix[c], {QW{1'b0}}} - {{QW{1'b0}}, i_pix[c]};
            trial[c] = {r_rem[c], r_low[c][QW-1]};
            take[c]  = trial[c] >= {1'b0, r_max[c]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(QW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < gpd_pkg::NUM_CH; c++) begin
            if (i_start) begin
                r_rem[c] <= prod[c][CB+QW-1:QW];
                r_low[c] <= prod[c][QW-1:0];
                r_q[c]   <= '0;
                r_max[c] <= i_max[c];
            end else if (r_busy) begin
                r_rem[c] <= take[c] ? CB'(trial[c] - {1'b0, r_max[c]}) : trial[c][CB-1:0];
                r_low[c] <= {r_low[c][QW-2:0], 1'b0};
                r_q[c]   <= {r_q[c][QW-2:0], take[c]};
            end
        end
    end

    always_comb begin
        for (int c = 0; c < gpd_pkg::NUM_CH; c++) begin
            o_q[c] = (r_max[c] == '0) ? '0 : r_q[c];
        end
    end

    assign o_done = r_done;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for gradient_predictor_decoder_core: directed and random pixel streams in and out.
// Depends on gpd_pkg and the core RTL; expected pixels come from a gradient predictor kept here.
module tb_top;
    import gpd_pkg::*;

    localparam int ROW_CAP       = MAX_ROW_WIDTH_DEF;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_item             i_in_data   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_RED_MAX;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    t_out_item            o_out_data;

    gradient_predictor_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Register copies and predictor state, at their reset values.
    logic [15:0] ch_max   [NUM_CH] = '{16'd255, 16'd255, 16'd255};
    logic [4:0]  ch_shift [NUM_CH] = '{5'd16, 5'd8, 5'd0};
    logic [11:0] row_len           = 12'd1;

    logic [15:0] prev_row_px [ROW_CAP][NUM_CH];
    logic [15:0] left_px     [NUM_CH] = '{16'd0, 16'd0, 16'd0};
    logic [15:0] upleft_px   [NUM_CH] = '{16'd0, 16'd0, 16'd0};
    int unsigned col_idx      = 0;
    bit          on_first_row = 1'b1;

    t_out_item   pending_pixels [$];
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned hold_left   = 0;
    int unsigned live_width  = 0;
    int          mismatch_count  = 0;
    int          pixels_sent     = 0;
    int          rect_starts     = 0;
    int          results_seen    = 0;
    int          row_ends_seen   = 0;
    int          formats_loaded  = 0;

    function automatic t_out_item reconstruct_pixel(t_in_item px);
        t_out_item        res;
        int unsigned      span;
        int unsigned      col;
        int               ch;
        int               up;
        int               lft;
        int               ul;
        int               est;
        logic [31:0]      sum;
        logic [15:0]      val;
        logic [31:0]      scaled;
        logic [2:0][7:0]  lanes;
        if (px.rect_start) begin
            col_idx      = 0;
            on_first_row = 1'b1;
        end
        span = (row_len == 0) ? 1 : ((row_len > ROW_CAP) ? ROW_CAP : row_len);
        col  = (col_idx >= ROW_CAP) ? 0 : col_idx;
        for (ch = 0; ch < NUM_CH; ch++) begin
            up  = on_first_row ? 0 : int'(prev_row_px[col][ch]);
            lft = (col == 0) ? 0 : int'(left_px[ch]);
            ul  = (col == 0) ? 0 : int'(upleft_px[ch]);
            est = lft + up - ul;
            if (est > int'(ch_max[ch])) begin
                est = int'(ch_max[ch]);
            end else if (est < 0) begin
                est = 0;
            end
            sum    = (px.residual_word >> ch_shift[ch]) + 32'(est);
            val    = sum[15:0] & ch_max[ch];
            scaled = (ch_max[ch] == '0) ? 32'd0 : (32'(val) * 32'd255) / 32'(ch_max[ch]);
            lanes[ch]             = scaled[7:0];
            upleft_px[ch]         = 16'(up);
            left_px[ch]           = val;
            prev_row_px[col][ch]  = val;
        end
        res.red_out   = lanes[0];
        res.green_out = lanes[1];
        res.blue_out  = lanes[2];
        if (col + 1 >= span) begin
            res.row_end  = 1'b1;
            col_idx      = 0;
            on_first_row = 1'b0;
        end else begin
            res.row_end = 1'b0;
            col_idx     = col + 1;
        end
        return res;
    endfunction

    task automatic log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 30) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic push_pixel(logic [31:0] word, logic rect);
        t_in_item px;
        px.residual_word = word;
        px.rect_start    = rect;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        pending_pixels.push_back(reconstruct_pixel(px));
        pixels_sent++;
        if (rect) begin
            rect_starts++;
        end
    endtask

    task automatic wait_pixels_drained();
        int guard;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_pixels.size() != 0 && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        if (pending_pixels.size() != 0) begin
            log_mismatch($sformatf("%0d expected pixels never came out", pending_pixels.size()));
            pending_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_RED_MAX:     ch_max[0]   = data;
            CFG_GREEN_MAX:   ch_max[1]   = data;
            CFG_BLUE_MAX:    ch_max[2]   = data;
            CFG_RED_SHIFT:   ch_shift[0] = data[4:0];
            CFG_GREEN_SHIFT: ch_shift[1] = data[4:0];
            CFG_BLUE_SHIFT:  ch_shift[2] = data[4:0];
            CFG_ROW_WIDTH:   row_len     = data[11:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_format(logic [15:0] r_max, logic [15:0] g_max, logic [15:0] b_max,
                               logic [4:0] r_sh, logic [4:0] g_sh, logic [4:0] b_sh,
                               logic [11:0] px_per_row);
        @(negedge i_clk);
        cfg_write(CFG_RED_MAX, r_max);
        cfg_write(CFG_GREEN_MAX, g_max);
        cfg_write(CFG_BLUE_MAX, b_max);
        cfg_write(CFG_RED_SHIFT, 16'(r_sh));
        cfg_write(CFG_GREEN_SHIFT, 16'(g_sh));
        cfg_write(CFG_BLUE_SHIFT, 16'(b_sh));
        cfg_write(CFG_ROW_WIDTH, 16'(px_per_row));
        i_cfg_we <= 1'b0;
        formats_loaded++;
    endtask

    function automatic logic [15:0] pick_channel_max();
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            return 16'((17'd1 << $urandom_range(16, 1)) - 17'd1);
        end
        if (r < 95) begin
            return 16'($urandom_range(65535, 1));
        end
        return '0;
    endfunction

    function automatic logic [31:0] pick_residual();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            return $urandom();
        end
        if (r < 70) begin
            return 32'd0;
        end
        if (r < 80) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom() & $urandom() & $urandom();
    endfunction

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_output
        t_out_item want;
        string     bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                log_mismatch("output transfer with no pixel expected");
            end else begin
                want = pending_pixels.pop_front();
                bad  = "";
                if (o_out_data.red_out !== want.red_out) begin
                    bad = {bad, $sformatf(" red %0d/%0d", o_out_data.red_out, want.red_out)};
                end
                if (o_out_data.green_out !== want.green_out) begin
                    bad = {bad, $sformatf(" green %0d/%0d", o_out_data.green_out,
                                          want.green_out)};
                end
                if (o_out_data.blue_out !== want.blue_out) begin
                    bad = {bad, $sformatf(" blue %0d/%0d", o_out_data.blue_out, want.blue_out)};
                end
                if (o_out_data.row_end !== want.row_end) begin
                    bad = {bad, $sformatf(" row_end %0b/%0b", o_out_data.row_end, want.row_end)};
                end
                if (bad != "") begin
                    log_mismatch($sformatf("pixel %0d got/expected:%s", results_seen, bad));
                end
            end
            if (o_out_data.row_end === 1'b1) begin
                row_ends_seen++;
            end
            results_seen++;
        end
    end

    task automatic test_reset_defaults();
        push_pixel(32'h0012_3456, 1'b1);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h0080_8080, 1'b0);
    endtask

    task automatic test_full_scale_extremes();
        wait_pixels_drained();
        load_format(16'd255, 16'd255, 16'd255, 5'd16, 5'd8, 5'd0, 12'd3);
        push_pixel(32'hFFFF_FFFF, 1'b1);
        push_pixel(32'h0000_0000, 1'b0);
        push_pixel(32'h0001_0101, 1'b0);
        push_pixel(32'h00FF_00FF, 1'b0);
        push_pixel(32'h8080_8080, 1'b0);
        push_pixel(32'h7FFF_FFFF, 1'b0);
    endtask

    task automatic test_odd_channel_formats();
        wait_pixels_drained();
        load_format(16'd0, 16'h00F0, 16'hFFFF, 5'd31, 5'd20, 5'd0, 12'd2);
        push_pixel(32'hFFFF_FFFF, 1'b1);
        push_pixel(32'h80F0_ABCD, 1'b0);
        push_pixel(32'h7FF5_FFFF, 1'b0);
        push_pixel(32'h0000_0001, 1'b0);
    endtask

    task automatic test_row_width_limits();
        wait_pixels_drained();
        load_format(16'd255, 16'd255, 16'd255, 5'd16, 5'd8, 5'd0, 12'd0);
        push_pixel(32'h00AB_CDEF, 1'b1);
        push_pixel(32'h0054_3210, 1'b0);
        wait_pixels_drained();
        load_format(16'd255, 16'd255, 16'd255, 5'd16, 5'd8, 5'd0, 12'd2048);
        push_pixel(32'h0011_2233, 1'b1);
        push_pixel(32'h00EE_DDCC, 1'b0);
        wait_pixels_drained();
        load_format(16'd255, 16'd255, 16'd255, 5'd16, 5'd8, 5'd0, 12'hFFF);
        push_pixel(32'h00F0_0F0F, 1'b1);
        push_pixel(32'h000F_F0F0, 1'b0);
    endtask

    task automatic test_width_lowered_mid_row();
        int k;
        wait_pixels_drained();
        load_format(16'd255, 16'd255, 16'd255, 5'd16, 5'd8, 5'd0, 12'd8);
        for (k = 0; k < 5; k++) begin
            push_pixel(pick_residual(), k == 0);
        end
        wait_pixels_drained();
        load_format(16'd255, 16'd255, 16'd255, 5'd16, 5'd8, 5'd0, 12'd3);
        for (k = 0; k < 4; k++) begin
            push_pixel(pick_residual(), 1'b0);
        end
    endtask

    task automatic test_random_images(int budget);
        int  left_items;
        int  plan;
        int  cut;
        int  r;
        int  k;
        int  w;
        int  w2;
        bit  cont;
        bit  lower;
        left_items = budget;
        while (left_items > 0) begin
            r = $urandom_range(99);
            if (r < 60) begin
                w = $urandom_range(8, 1);
            end else if (r < 85) begin
                w = $urandom_range(40, 9);
            end else if (r < 97) begin
                w = $urandom_range(200, 41);
            end else begin
                w = $urandom_range(300, 201);
            end
            plan = (w * 4 > 120) ? w + $urandom_range(30, 1)
                                 : w * $urandom_range(4, 2) + $urandom_range(w, 0);
            if (plan > left_items) begin
                plan = left_items;
            end
            // Carrying on without a rectangle start is safe only if the row does not grow.
            cont  = (w <= live_width) && ($urandom_range(99) < 25);
            lower = ($urandom_range(99) < 20) && (plan > 1);
            cut   = lower ? $urandom_range(plan - 1, 1) : 0;
            wait_pixels_drained();
            load_format(pick_channel_max(), pick_channel_max(), pick_channel_max(),
                        5'($urandom_range(31)), 5'($urandom_range(31)),
                        5'($urandom_range(31)), 12'(w));
            live_width = w;
            for (k = 0; k < plan; k++) begin
                if (lower && k == cut) begin
                    wait_pixels_drained();
                    w2 = $urandom_range(w, 1);
                    load_format(ch_max[0], ch_max[1], ch_max[2],
                                ch_shift[0], ch_shift[1], ch_shift[2], 12'(w2));
                    live_width = w2;
                end
                push_pixel(pick_residual(), (k == 0 && !cont) || ($urandom_range(99) < 3));
            end
            left_items -= plan;
        end
    endtask

    task automatic test_output_backpressure();
        int k;
        wait_pixels_drained();
        load_format(16'd255, 16'd255, 16'd255, 5'd16, 5'd8, 5'd0, 12'd5);
        hold_left = 300;
        for (k = 0; k < 40; k++) begin
            push_pixel(pick_residual(), k == 0);
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 6;
        rx_idle_pct = 59;
        test_reset_defaults();
        test_full_scale_extremes();
        test_odd_channel_formats();
        test_row_width_limits();
        test_width_lowered_mid_row();
        test_random_images(300);
        tx_idle_pct = 59;
        rx_idle_pct = 6;
        test_random_images(300);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_images(300);
        test_output_backpressure();
        wait_pixels_drained();
        $display("Sent %0d pixels with %0d rectangle starts over %0d register loads.",
                 pixels_sent, rect_starts, formats_loaded);
        $display("Checked %0d output transfers, %0d row ends, %0d mismatches.",
                 results_seen, row_ends_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
